[design/itahp_pkg.sv]
package itahp_pkg;

    localparam int ADDR_ENTRIES_DEF = 256;
    localparam int PORT_AW = 16;
    localparam int PORT_DEPTH = 65536;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [31:0] LOOPBACK = 32'h7F00_0001;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam logic [1:0] KIND_OUT = 2'd2;
    localparam logic [15:0] TIMEOUT_RST = 16'd30;
    localparam int IN_FIELDS_W = 170;
    localparam int IN_W = 176;
    localparam int OUT_W = 216;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_WAIT,
        ST_DECIDE,
        ST_COUNT,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic search_start;
        logic search_step;
        logic decide;
        logic count;
        logic write;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic clr_done;
        logic search_done;
    } stat_t;

endpackage

[design/ip_traffic_accounting_hole_punch.sv]
// IPv4 traffic accounting with UDP hole-punch detection. One descriptor at a
// time: after a transfer the remote is searched in the address table one entry
// per cycle, and the next transfer is taken only once the result of the
// previous one has been loaded into the output register; unhandled packets
// skip the scan. A result that is not taken holds the block in its output
// state. After reset a pass clears the 65536-entry port table, one entry a
// cycle, during which s_tready stays low; configuration writes are taken at
// any time.
module ip_traffic_accounting_hole_punch #(
    parameter int ADDR_ENTRIES = itahp_pkg::ADDR_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [15:0]                  cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // pkt_kind, ethertype, src_addr, dst_addr, ip_proto, src_port, dst_port,
    // pkt_length, time_now, zero fill
    input  logic [itahp_pkg::IN_W-1:0]   s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // counted, table_full, remote_addr, sent_total, recv_total, hole_punch,
    // punch_port, previous_remote, zero fill
    output logic [itahp_pkg::OUT_W-1:0]  m_tdata
);

    itahp_pkg::ctrl_t ctrl;
    itahp_pkg::stat_t stat;

    itahp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .stat(stat), .ctrl(ctrl));

    itahp_dp #(.ADDR_ENTRIES(ADDR_ENTRIES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tdata(s_tdata[itahp_pkg::IN_FIELDS_W-1:0]), .m_tdata(m_tdata),
        .ctrl(ctrl), .stat(stat));

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted twice in a row");

    a_out_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("counted and table_full together");

    a_punch_port: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[162]) |-> (m_tdata[210:163] == 48'd0))
        else $error("punch fields without hole punch");

endmodule

[design/itahp_ram.sv]
module itahp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                           aclk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/itahp_ctrl.sv]
module itahp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  itahp_pkg::stat_t  stat,
    output itahp_pkg::ctrl_t  ctrl
);

    itahp_pkg::state_t state_reg, state_next;
    logic mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= itahp_pkg::ST_CLEAR;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        ctrl        = '0;
        s_tready    = 1'b0;
        case (state_reg)
            itahp_pkg::ST_CLEAR: begin
                ctrl.clr_step = 1'b1;
                if (stat.clr_done) begin
                    state_next = itahp_pkg::ST_IDLE;
                end
            end
            itahp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.load = 1'b1;
                    state_next = itahp_pkg::ST_SEARCH;
                end
            end
            itahp_pkg::ST_SEARCH: begin
                ctrl.search_start = 1'b1;
                state_next = itahp_pkg::ST_WAIT;
            end
            itahp_pkg::ST_WAIT: begin
                // one entry per cycle until the scan ends
                ctrl.search_step = 1'b1;
                if (stat.search_done) begin
                    state_next = itahp_pkg::ST_DECIDE;
                end
            end
            itahp_pkg::ST_DECIDE: begin
                ctrl.decide = 1'b1;
                state_next = itahp_pkg::ST_COUNT;
            end
            itahp_pkg::ST_COUNT: begin
                ctrl.count = 1'b1;
                state_next = itahp_pkg::ST_WRITE;
            end
            itahp_pkg::ST_WRITE: begin
                ctrl.write = 1'b1;
                state_next = itahp_pkg::ST_OUT;
            end
            itahp_pkg::ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    ctrl.out_load = 1'b1;
                    mvalid_next = 1'b1;
                    state_next = itahp_pkg::ST_IDLE;
                end
            end
            default: state_next = itahp_pkg::ST_IDLE;
        endcase
    end

endmodule

[design/itahp_dp.sv]
module itahp_dp #(
    parameter int ADDR_ENTRIES = itahp_pkg::ADDR_ENTRIES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [15:0]                         cfg_wdata,
    input  logic [itahp_pkg::IN_FIELDS_W-1:0]   s_tdata,
    output logic [itahp_pkg::OUT_W-1:0]         m_tdata,
    input  itahp_pkg::ctrl_t                    ctrl,
    output itahp_pkg::stat_t                    stat
);

    localparam int EW = (ADDR_ENTRIES > 1) ? $clog2(ADDR_ENTRIES) : 1;
    localparam int CW = $clog2(ADDR_ENTRIES + 1);
    localparam int PW = itahp_pkg::PORT_AW;

    logic [15:0] timeout_reg;
    logic [31:0] remote_reg, now_reg;
    logic [15:0] lport_reg, len_reg;
    logic        udp_reg, handled_reg, outgoing_reg;

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] scan_reg;
    logic [EW-1:0] hit_idx_reg, free_idx_reg;
    logic hit_reg, free_reg;
    logic [PW-1:0] clr_reg;
    logic clr_done_reg;
    logic [PW-1:0] pv_addr;

    logic [31:0] ea_rd;
    logic [63:0] es_rd, er_rd;
    logic [32:0] pr_rd;
    logic [31:0] ps_rd;
    logic        pv_rd;

    logic [EW-1:0] slot_reg;
    logic          have_slot_reg, newent_reg;
    logic [63:0]   sent_reg, recv_reg;
    logic          punch_reg;

    logic [EW-1:0] scan_idx;
    assign scan_idx = scan_reg[EW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= itahp_pkg::TIMEOUT_RST;
        end else if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end
    end

    // unpack and qualify the descriptor
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            outgoing_reg <= (s_tdata[1:0] == itahp_pkg::KIND_OUT);
            handled_reg  <= (s_tdata[1:0] != itahp_pkg::KIND_OTHER)
                         && (s_tdata[17:2] == itahp_pkg::ETH_IPV4)
                         && (s_tdata[81:50] != itahp_pkg::LOOPBACK);
            remote_reg   <= (s_tdata[1:0] == itahp_pkg::KIND_OUT) ? s_tdata[81:50]
                                                                  : s_tdata[49:18];
            udp_reg      <= (s_tdata[89:82] == itahp_pkg::PROTO_UDP);
            lport_reg    <= (s_tdata[1:0] == itahp_pkg::KIND_OUT) ? s_tdata[105:90]
                                                                  : s_tdata[121:106];
            len_reg      <= s_tdata[137:122];
            now_reg      <= s_tdata[169:138];
        end
    end

    // entries are taken from index 0 up and never freed, so a fill count
    // marks the valid ones
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (ctrl.write && handled_reg && newent_reg && have_slot_reg) begin
            fill_reg <= fill_reg + 1'b1;
        end
    end

    logic [EW-1:0] ea_raddr;
    logic [CW-1:0] prev_scan;
    logic          scan_live_reg;
    logic [EW-1:0] scan_q_reg;
    assign ea_raddr = scan_idx;
    assign prev_scan = scan_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.search_start) begin
            scan_reg <= '0;
            scan_live_reg <= 1'b0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            hit_idx_reg <= '0;
            free_idx_reg <= '0;
        end else if (ctrl.search_step) begin
            if (prev_scan < CW'(ADDR_ENTRIES)) begin
                scan_reg <= scan_reg + 1'b1;
            end
            scan_live_reg <= (prev_scan < CW'(ADDR_ENTRIES));
            scan_q_reg <= scan_idx;
            if (scan_live_reg) begin
                if (CW'(scan_q_reg) < fill_reg) begin
                    if (!hit_reg && ea_rd == remote_reg) begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= scan_q_reg;
                    end
                end else if (!free_reg) begin
                    free_reg <= 1'b1;
                    free_idx_reg <= scan_q_reg;
                end
            end
        end
    end

    assign stat.search_done = (ctrl.search_step && !scan_live_reg
                               && (scan_reg == CW'(ADDR_ENTRIES))) || !handled_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.decide) begin
            have_slot_reg <= hit_reg || free_reg;
            newent_reg <= !hit_reg;
            slot_reg <= hit_reg ? hit_idx_reg : free_idx_reg;
        end
    end

    logic [EW-1:0] cnt_raddr;
    assign cnt_raddr = hit_reg ? hit_idx_reg : free_idx_reg;

    logic [64:0] sum;
    logic [63:0] base;
    logic [63:0] sat;
    always_comb begin
        base = outgoing_reg ? (newent_reg ? 64'd0 : es_rd) : (newent_reg ? 64'd0 : er_rd);
        sum = {1'b0, base} + {49'd0, len_reg};
        sat = sum[64] ? {64{1'b1}} : sum[63:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.count) begin
            if (outgoing_reg) begin
                sent_reg <= sat;
                recv_reg <= newent_reg ? 64'd0 : er_rd;
            end else begin
                sent_reg <= newent_reg ? 64'd0 : es_rd;
                recv_reg <= sat;
            end
        end
    end

    logic cnt_we;
    assign cnt_we = ctrl.write && handled_reg && have_slot_reg;

    itahp_ram #(.WIDTH(32), .DEPTH(ADDR_ENTRIES)) u_ea (
        .aclk(aclk), .we(cnt_we && newent_reg), .waddr(slot_reg), .wdata(remote_reg),
        .raddr(ea_raddr), .rdata(ea_rd));
    itahp_ram #(.WIDTH(64), .DEPTH(ADDR_ENTRIES)) u_es (
        .aclk(aclk), .we(cnt_we), .waddr(slot_reg), .wdata(sent_reg),
        .raddr(cnt_raddr), .rdata(es_rd));
    itahp_ram #(.WIDTH(64), .DEPTH(ADDR_ENTRIES)) u_er (
        .aclk(aclk), .we(cnt_we), .waddr(slot_reg), .wdata(recv_reg),
        .raddr(cnt_raddr), .rdata(er_rd));

    // port table; valid bit kept beside the remote, cleared by a pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else if (ctrl.clr_step) begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == PW'(itahp_pkg::PORT_DEPTH - 1)) begin
                clr_done_reg <= 1'b1;
            end
        end
    end
    assign stat.clr_done = clr_done_reg;

    logic        pt_we;
    logic [32:0] pr_wd;
    assign pt_we = ctrl.clr_step || (ctrl.write && handled_reg && udp_reg);
    assign pv_addr = ctrl.clr_step ? clr_reg : lport_reg;
    assign pr_wd = ctrl.clr_step ? 33'd0 : {1'b1, remote_reg};

    itahp_ram #(.WIDTH(33), .DEPTH(itahp_pkg::PORT_DEPTH)) u_pr (
        .aclk(aclk), .we(pt_we), .waddr(pv_addr), .wdata(pr_wd),
        .raddr(lport_reg), .rdata(pr_rd));
    itahp_ram #(.WIDTH(32), .DEPTH(itahp_pkg::PORT_DEPTH)) u_ps (
        .aclk(aclk), .we(pt_we && !ctrl.clr_step), .waddr(pv_addr), .wdata(now_reg),
        .raddr(lport_reg), .rdata(ps_rd));
    assign pv_rd = pr_rd[32];

    logic [31:0] elapsed;
    assign elapsed = (now_reg >= ps_rd) ? now_reg - ps_rd : 32'd0;

    always_ff @(posedge aclk) begin
        if (ctrl.count) begin
            punch_reg <= udp_reg && pv_rd && (pr_rd[31:0] != remote_reg)
                      && (elapsed < {16'd0, timeout_reg});
        end
    end

    logic [31:0] prev_reg;
    always_ff @(posedge aclk) begin
        if (ctrl.count) begin
            prev_reg <= pr_rd[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            if (!handled_reg) begin
                m_tdata <= '0;
            end else begin
                m_tdata <= {
                    5'd0,
                    (punch_reg ? prev_reg : 32'd0),
                    (punch_reg ? lport_reg : 16'd0),
                    punch_reg,
                    (have_slot_reg ? recv_reg : 64'd0),
                    (have_slot_reg ? sent_reg : 64'd0),
                    remote_reg,
                    !have_slot_reg,
                    have_slot_reg};
            end
        end
    end

endmodule

[bench/ip_traffic_accounting_hole_punch_test.sv]
module ip_traffic_accounting_hole_punch_test;

    localparam int ENTRIES = 256;

    typedef struct {
        bit [1:0]  kind;
        bit [15:0] etype;
        bit [31:0] src;
        bit [31:0] dst;
        bit [7:0]  proto;
        bit [15:0] sport;
        bit [15:0] dport;
        bit [15:0] len;
        bit [31:0] now;
    } pkt_t;

    typedef struct {
        bit        counted;
        bit        full;
        bit [31:0] remote;
        bit [63:0] sent;
        bit [63:0] recv;
        bit        punch;
        bit [15:0] pport;
        bit [31:0] prev;
    } acct_t;

    typedef struct {
        pkt_t  p;
        bit    typed;
        acct_t e;
    } row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [15:0]                   cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [itahp_pkg::IN_W-1:0]    s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [itahp_pkg::OUT_W-1:0]   m_tdata;

    // counter table and port table of the predictor
    bit        tab_valid [ENTRIES];
    bit [31:0] tab_addr [ENTRIES];
    bit [63:0] tab_sent [ENTRIES];
    bit [63:0] tab_recv [ENTRIES];
    bit [31:0] port_last_remote [int];
    bit [31:0] port_last_seen [int];
    bit [15:0] punch_window = itahp_pkg::TIMEOUT_RST;

    acct_t     acct_queue[$];
    bit        failed = 1'b0;
    int        rx_wait = 0;
    int        rx_hold = 0;
    int        rx_done = 0;
    bit        rx_idle_on = 1'b1;
    bit        tx_idle_on = 1'b1;
    bit [31:0] clock_s = 32'd1000;

    ip_traffic_accounting_hole_punch DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic acct_t account_pkt(pkt_t p);
        acct_t r = '{default: '0};
        bit outgoing;
        int hit = -1;
        int free_idx = -1;
        int lp;
        bit [31:0] elapsed;
        if (p.kind == itahp_pkg::KIND_OTHER || p.etype != itahp_pkg::ETH_IPV4
            || p.dst == itahp_pkg::LOOPBACK)
            return r;
        outgoing = (p.kind == itahp_pkg::KIND_OUT);
        r.remote = outgoing ? p.dst : p.src;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tab_valid[i]) begin
                if (hit < 0 && tab_addr[i] == r.remote) hit = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (hit < 0 && free_idx >= 0) begin
            hit = free_idx;
            tab_valid[hit] = 1'b1;
            tab_addr[hit] = r.remote;
            tab_sent[hit] = '0;
            tab_recv[hit] = '0;
        end
        if (hit < 0) begin
            r.full = 1'b1;
        end else begin
            // saturating add
            if (outgoing)
                tab_sent[hit] = (tab_sent[hit] + p.len < tab_sent[hit]) ? '1
                                : tab_sent[hit] + p.len;
            else
                tab_recv[hit] = (tab_recv[hit] + p.len < tab_recv[hit]) ? '1
                                : tab_recv[hit] + p.len;
            r.counted = 1'b1;
            r.sent = tab_sent[hit];
            r.recv = tab_recv[hit];
        end
        if (p.proto == itahp_pkg::PROTO_UDP) begin
            lp = outgoing ? p.sport : p.dport;
            if (port_last_remote.exists(lp) && port_last_remote[lp] != r.remote) begin
                elapsed = (p.now >= port_last_seen[lp]) ? p.now - port_last_seen[lp] : '0;
                if (elapsed < {16'd0, punch_window}) begin
                    r.punch = 1'b1;
                    r.pport = lp[15:0];
                    r.prev = port_last_remote[lp];
                end
            end
            port_last_remote[lp] = r.remote;
            port_last_seen[lp] = p.now;
        end
        return r;
    endfunction

    task automatic offer_pkt(pkt_t p, bit typed, acct_t e);
        int gap;
        acct_t r;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= itahp_pkg::IN_W'({p.now, p.len, p.dport, p.sport, p.proto, p.dst,
                                     p.src, p.etype, p.kind});
        r = account_pkt(p);
        acct_queue.push_back(typed ? e : r);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic set_window(bit [15:0] v);
        s_tvalid <= 1'b0;
        wait (acct_queue.size() == 0);
        repeat (300) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        punch_window = v;
    endtask

    function automatic pkt_t random_pkt();
        pkt_t p;
        bit [31:0] remote;
        int sel;
        p.kind = ($urandom_range(0, 9) == 0) ? itahp_pkg::KIND_OTHER
                                             : 2'($urandom_range(0, 2));
        p.etype = ($urandom_range(0, 12) == 0) ? 16'($urandom) : itahp_pkg::ETH_IPV4;
        sel = $urandom_range(0, 19);
        // a pool a bit larger than the table, so it fills up over the run
        remote = (sel == 0) ? $urandom : 32'h0A00_0000 + $urandom_range(0, 330);
        p.src = $urandom;
        p.dst = $urandom;
        if (p.kind == itahp_pkg::KIND_OUT) p.dst = remote;
        else p.src = remote;
        if ($urandom_range(0, 40) == 0) p.dst = itahp_pkg::LOOPBACK;
        p.proto = ($urandom_range(0, 3) == 0) ? 8'($urandom) : itahp_pkg::PROTO_UDP;
        p.sport = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        p.dport = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        p.len = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        sel = $urandom_range(0, 19);
        if (sel == 0) clock_s = $urandom;
        else if (sel == 1) clock_s = clock_s - $urandom_range(0, 40);
        else clock_s = clock_s + $urandom_range(0, 12);
        p.now = clock_s;
        return p;
    endfunction

    // result side with its own stall control
    always @(posedge aclk) begin
        acct_t e;
        acct_t a;
        logic [215:0] bits;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                bits = 216'(m_tdata);
                a.counted = bits[0];
                a.full = bits[1];
                a.remote = bits[33:2];
                a.sent = bits[97:34];
                a.recv = bits[161:98];
                a.punch = bits[162];
                a.pport = bits[178:163];
                a.prev = bits[210:179];
                if (acct_queue.size() == 0) begin
                    $display("%0t: unexpected transfer %h", $time, m_tdata);
                    failed = 1'b1;
                end else begin
                    e = acct_queue.pop_front();
                    if (a != e) begin
                        failed = 1'b1;
                        $display("%0t: expected cnt=%b full=%b rem=%h sent=%h recv=%h hp=%b port=%h prev=%h",
                                 $time, e.counted, e.full, e.remote, e.sent, e.recv,
                                 e.punch, e.pport, e.prev);
                        $display("%0t: actual   cnt=%b full=%b rem=%h sent=%h recv=%h hp=%b port=%h prev=%h",
                                 $time, a.counted, a.full, a.remote, a.sent, a.recv,
                                 a.punch, a.pport, a.prev);
                    end
                end
                rx_done++;
                if (rx_done == 300) rx_hold = 3000;
                rx_wait = rx_idle_on ? $urandom_range(0, 19) : 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #60_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        row_t rows[12];
        acct_t none;
        none = '{default: '0};
        rows = '{
            '{'{2'd3, 16'h0800, 32'h0A000001, 32'h0A000002, 8'd17, 16'd1, 16'd2,
                16'd100, 32'd10}, 1, none},
            '{'{2'd0, 16'h86DD, 32'h0A000001, 32'h0A000002, 8'd17, 16'd1, 16'd2,
                16'd100, 32'd10}, 1, none},
            '{'{2'd0, 16'h0800, 32'h0A000001, 32'h7F000001, 8'd17, 16'd1, 16'd2,
                16'd100, 32'd10}, 1, none},
            '{'{2'd2, 16'h0800, 32'h0, 32'hFFFFFFFF, 8'd6, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 32'd10}, 1,
              '{1'b1, 1'b0, 32'hFFFFFFFF, 64'hFFFF, 64'h0, 1'b0, 16'h0, 32'h0}},
            '{'{2'd0, 16'h0800, 32'hFFFFFFFF, 32'h0, 8'd6, 16'h0, 16'h0,
                16'hFFFF, 32'd11}, 1,
              '{1'b1, 1'b0, 32'hFFFFFFFF, 64'hFFFF, 64'hFFFF, 1'b0, 16'h0, 32'h0}},
            '{'{2'd1, 16'h0800, 32'h0, 32'h1, 8'd17, 16'h0, 16'h0,
                16'd0, 32'd0}, 1,
              '{1'b1, 1'b0, 32'h0, 64'h0, 64'h0, 1'b0, 16'h0, 32'h0}},
            '{'{2'd0, 16'h0800, 32'h1, 32'h2, 8'd17, 16'h0, 16'h0,
                16'd1, 32'd5}, 1,
              '{1'b1, 1'b0, 32'h1, 64'h0, 64'h1, 1'b1, 16'h0, 32'h0}},
            // time going backwards on the same port
            '{'{2'd2, 16'h0800, 32'h0, 32'h2, 8'd17, 16'h0, 16'h7,
                16'd20, 32'd3}, 0, none},
            '{'{2'd2, 16'h0800, 32'h0, 32'h2, 8'd17, 16'h0, 16'h7,
                16'd20, 32'd100}, 0, none},
            '{'{2'd0, 16'h0800, 32'h3, 32'h0, 8'd17, 16'h0, 16'hFFFF,
                16'd7, 32'hFFFFFFFF}, 0, none},
            '{'{2'd2, 16'h0800, 32'h0, 32'h4, 8'd17, 16'hFFFF, 16'h0,
                16'd8, 32'd0}, 0, none},
            // remote change after the window has passed
            '{'{2'd1, 16'h0800, 32'h5, 32'h0, 8'd17, 16'h0, 16'h0,
                16'd9, 32'd200}, 0, none}
        };
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (rows[i]) offer_pkt(rows[i].p, rows[i].typed, rows[i].e);
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_window(16'd0);
                1: set_window(16'hFFFF);
                2: set_window(16'($urandom_range(1, 60)));
                3: set_window(16'd1);
                default: set_window(16'($urandom));
            endcase
            rx_idle_on = (ph != 2);
            tx_idle_on = (ph != 3);
            for (int n = 0; n < 150; n++) offer_pkt(random_pkt(), 1'b0, none);
        end
        s_tvalid <= 1'b0;
        wait (acct_queue.size() == 0);
        repeat (300) @(posedge aclk);
        if (!failed && acct_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
design/itahp_pkg.sv
design/itahp_ram.sv
design/itahp_ctrl.sv
design/itahp_dp.sv
design/ip_traffic_accounting_hole_punch.sv
bench/ip_traffic_accounting_hole_punch_test.sv
